// ===== src/geodetic_to_ecef_macros.svh =====
// ----------------------------------------------------------------------------
// geodetic_to_ecef_macros.svh
// Assertion helpers for the geodetic to ECEF converter.
// ----------------------------------------------------------------------------
`ifndef GEODETIC_TO_ECEF_MACROS_SVH
`define GEODETIC_TO_ECEF_MACROS_SVH

// Same-cycle implication, checked outside reset
`define G2E_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define G2E_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is seen
`define G2E_CHECK_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

// ===== src/g2e_pkg.sv =====
// ----------------------------------------------------------------------------
// g2e_pkg
// Shared types, constants and helpers of the geodetic to ECEF converter.
// ----------------------------------------------------------------------------
package g2e_pkg;

  // Field widths
  localparam int LAT_W    = 31;
  localparam int LON_W    = 32;
  localparam int ALT_W    = 28;
  localparam int OUT_W    = 34;
  localparam int RADIUS_W = 33;
  localparam int ECC_W    = 37;
  localparam int ECC_FRAC = 40;
  localparam int CFG_W    = 37;
  localparam int CFG_IDX_W = 1;
  localparam int MAG_W    = 32;

  // Fixed-point format: Q60 fractions, Q20 millimetres
  localparam int QBITS     = 60;
  localparam int LEN_FRAC  = 20;
  localparam int ANGLE_FRACTION_BITS_DEF = 29;

  // Pipeline shape
  localparam int RED_BITS_PER_STAGE = 4;
  localparam int TAYLOR_TERMS = 25;
  localparam int NEWTON_STEPS = 6;
  localparam int FIFO_DEPTH   = 4;

  typedef logic [63:0] q60_t;

  localparam q60_t ONE_Q60   = 64'h1000_0000_0000_0000;
  localparam q60_t THREE_Q60 = 64'h3000_0000_0000_0000;
  localparam q60_t TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
  localparam logic signed [63:0] PI_Q60      = 64'sh3243_F6A8_885A_308D;
  localparam logic signed [63:0] HALF_PI_Q60 = 64'sh1921_FB54_442D_1846;
  localparam q60_t OUT_LIMIT_U = 64'd6500000000;
  localparam logic signed [OUT_W-1:0] OUT_LIMIT = 34'sd6500000000;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 33'd6378137000;
  localparam logic [ECC_W-1:0]    ECC_RESET    = 37'd7360548647;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 1'b0,
    CFG_ECC    = 1'b1
  } cfg_index_t;

  // One angle after reduction and folding
  typedef struct packed {
    q60_t m;
    logic rneg;
    logic cneg;
  } angle_t;

  // Queue entry between front and back
  typedef struct packed {
    angle_t lat;
    angle_t lon;
    logic signed [ALT_W-1:0] alt;
  } point_t;

  // Series evaluation state
  typedef struct packed {
    q60_t lat_t, lat_s, lat_c;
    q60_t lon_t, lon_s, lon_c;
    angle_t lat;
    angle_t lon;
    logic signed [ALT_W-1:0] alt;
  } trig_t;

  // Radius and coordinate state
  typedef struct packed {
    q60_t sl, cl, so, co;
    q60_t w, y, n, p, pz, pcl, z;
    logic signed [ALT_W-1:0] alt;
  } geo_t;

  function automatic q60_t mag64(input q60_t v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic q60_t neg_if(input q60_t v, input logic n);
    return n ? (64'd0 - v) : v;
  endfunction

endpackage

// ===== src/g2e_if.sv =====
// ----------------------------------------------------------------------------
// g2e_in_if / g2e_out_if
// Valid/ready channels for geodetic points and ECEF results.
// ----------------------------------------------------------------------------
interface g2e_in_if;
  import g2e_pkg::*;
  logic valid;
  logic ready;
  logic signed [LAT_W-1:0] latitude_rad;
  logic signed [LON_W-1:0] longitude_rad;
  logic signed [ALT_W-1:0] altitude_mm;
  modport source(output valid, latitude_rad, longitude_rad, altitude_mm, input ready);
  modport sink(input valid, latitude_rad, longitude_rad, altitude_mm, output ready);
endinterface

interface g2e_out_if;
  import g2e_pkg::*;
  logic valid;
  logic ready;
  logic signed [OUT_W-1:0] ecef_x_mm;
  logic signed [OUT_W-1:0] ecef_y_mm;
  logic signed [OUT_W-1:0] ecef_z_mm;
  modport source(output valid, ecef_x_mm, ecef_y_mm, ecef_z_mm, input ready);
  modport sink(input valid, ecef_x_mm, ecef_y_mm, ecef_z_mm, output ready);
endinterface

// ===== src/g2e_mulq.sv =====
// ----------------------------------------------------------------------------
// g2e_mulq
// Two-stage fixed-point multiplier: 32x32 partial products, then sum and shift.
// ----------------------------------------------------------------------------
module g2e_mulq #(
  parameter int  LANES      = 1,
  parameter type SIDE_T     = logic,
  parameter int  SHIFT      = g2e_pkg::QBITS,
  parameter bit  ROUND_HALF = 1'b1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][63:0]       a,
  input  logic [LANES-1:0][63:0]       b,
  input  SIDE_T                        side_in,
  output logic                         out_valid,
  output logic [LANES-1:0][63:0]       p,
  output SIDE_T                        side_out
);
  import g2e_pkg::*;

  localparam logic [127:0] ROUND = ROUND_HALF ? (128'd1 << (SHIFT - 1)) : 128'd0;

  logic [LANES-1:0][3:0][63:0] pp;
  logic [LANES-1:0][127:0]     sum;
  logic                        v1;
  SIDE_T                       side1;

  // Valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // Partial products
  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side_in;
      for (int l = 0; l < LANES; l++) begin
        pp[l][0] <= a[l][31:0]  * b[l][31:0];
        pp[l][1] <= a[l][31:0]  * b[l][63:32];
        pp[l][2] <= a[l][63:32] * b[l][31:0];
        pp[l][3] <= a[l][63:32] * b[l][63:32];
      end
    end
  end

  // Sum, optionally round half up, drop SHIFT fraction bits
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum[l] = {64'd0, pp[l][0]} + {32'd0, pp[l][1], 32'd0}
             + {32'd0, pp[l][2], 32'd0} + {pp[l][3], 64'd0} + ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side1;
      for (int l = 0; l < LANES; l++) begin
        p[l] <= 64'(sum[l] >> SHIFT);
      end
    end
  end

endmodule

// ===== src/g2e_front.sv =====
// ----------------------------------------------------------------------------
// g2e_front
// Takes points, reduces both angles modulo 2*pi and folds them.
// ----------------------------------------------------------------------------
module g2e_front #(
  parameter int ANGLE_FRACTION_BITS = g2e_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  g2e_in_if.sink          geo,
  output logic            pt_valid,
  input  logic            pt_ready,
  output g2e_pkg::point_t pt
);
  import g2e_pkg::*;

  localparam int RED_STEPS  = MAG_W + QBITS - ANGLE_FRACTION_BITS;
  localparam int RED_STAGES = (RED_STEPS + RED_BITS_PER_STAGE - 1) / RED_BITS_PER_STAGE;

  typedef struct packed {
    logic [MAG_W-1:0] lat_mag, lon_mag;
    logic lat_neg, lon_neg;
    q60_t lat_rem, lon_rem;
    logic signed [ALT_W-1:0] alt;
  } red_t;

  // One shift-and-subtract step of the reduction
  function automatic q60_t red_step(input q60_t rem, input logic bin);
    q60_t nrem;
    nrem = {rem[62:0], bin};
    if (nrem >= TWO_PI_Q60) nrem = nrem - TWO_PI_Q60;
    return nrem;
  endfunction

  // Map the reduced angle into [-pi/2, pi/2]
  function automatic angle_t fold(input q60_t rem, input logic neg);
    logic signed [63:0] r;
    angle_t o;
    r = $signed(rem);
    if (r >= PI_Q60) r = r - $signed(TWO_PI_Q60);
    if (neg) r = -r;
    o.cneg = 1'b0;
    if (r > HALF_PI_Q60) begin
      r = PI_Q60 - r;
      o.cneg = 1'b1;
    end else if (r < -HALF_PI_Q60) begin
      r = -PI_Q60 - r;
      o.cneg = 1'b1;
    end
    o.rneg = r[63];
    o.m    = mag64(r);
    return o;
  endfunction

  red_t              st [RED_STAGES+1];
  logic [RED_STAGES:0] vld;
  logic              en;
  logic [MAG_W-1:0]  lat_ext;

  assign en        = !vld[RED_STAGES] || pt_ready;
  assign geo.ready = en;
  assign lat_ext   = {geo.latitude_rad[LAT_W-1], geo.latitude_rad};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RED_STAGES-1:0], geo.valid};
    end
  end

  // Input register: magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      st[0].lat_neg <= geo.latitude_rad[LAT_W-1];
      st[0].lat_mag <= geo.latitude_rad[LAT_W-1] ? (MAG_W'(0) - lat_ext) : lat_ext;
      st[0].lon_neg <= geo.longitude_rad[LON_W-1];
      st[0].lon_mag <= geo.longitude_rad[LON_W-1] ? (MAG_W'(0) - geo.longitude_rad)
                                                  : geo.longitude_rad;
      st[0].lat_rem <= '0;
      st[0].lon_rem <= '0;
      st[0].alt     <= geo.altitude_mm;
    end
  end

  // Reduction stages, a few bits each
  for (genvar s = 0; s < RED_STAGES; s++) begin : g_red
    q60_t lr [RED_BITS_PER_STAGE+1];
    q60_t or_ [RED_BITS_PER_STAGE+1];
    red_t nx;

    assign lr[0]  = st[s].lat_rem;
    assign or_[0] = st[s].lon_rem;

    for (genvar j = 0; j < RED_BITS_PER_STAGE; j++) begin : g_bit
      localparam int IDX = s * RED_BITS_PER_STAGE + j;
      if (IDX < MAG_W) begin : g_data
        assign lr[j+1]  = red_step(lr[j],  st[s].lat_mag[MAG_W-1-IDX]);
        assign or_[j+1] = red_step(or_[j], st[s].lon_mag[MAG_W-1-IDX]);
      end else if (IDX < RED_STEPS) begin : g_zero
        assign lr[j+1]  = red_step(lr[j],  1'b0);
        assign or_[j+1] = red_step(or_[j], 1'b0);
      end else begin : g_pass
        assign lr[j+1]  = lr[j];
        assign or_[j+1] = or_[j];
      end
    end

    always_comb begin
      nx         = st[s];
      nx.lat_rem = lr[RED_BITS_PER_STAGE];
      nx.lon_rem = or_[RED_BITS_PER_STAGE];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s+1] <= nx;
      end
    end
  end

  // Fold and hand to the queue
  assign pt_valid = vld[RED_STAGES];
  assign pt.lat   = fold(st[RED_STAGES].lat_rem, st[RED_STAGES].lat_neg);
  assign pt.lon   = fold(st[RED_STAGES].lon_rem, st[RED_STAGES].lon_neg);
  assign pt.alt   = st[RED_STAGES].alt;

endmodule

// ===== src/g2e_queue.sv =====
// ----------------------------------------------------------------------------
// g2e_queue
// Small FIFO that decouples the angle front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module g2e_queue #(
  parameter int DEPTH = g2e_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  g2e_pkg::point_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output g2e_pkg::point_t pop_data
);
  import g2e_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  point_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(push) - CW'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== src/g2e_back.sv =====
// ----------------------------------------------------------------------------
// g2e_back
// Arithmetic pipeline: sine/cosine series, 1/sqrt Newton steps, coordinates.
// ----------------------------------------------------------------------------
module g2e_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pt_valid,
  output logic                            pt_ready,
  input  g2e_pkg::point_t                 pt,
  input  logic [g2e_pkg::RADIUS_W-1:0]    radius,
  input  logic [g2e_pkg::ECC_W-1:0]       ecc,
  g2e_out_if.source                       ecef
);
  import g2e_pkg::*;

  logic en;
  q60_t e2, one_minus_e2, radius_q;

  assign en       = !ecef.valid || ecef.ready;
  assign pt_ready = en;

  assign e2 = {{(64-ECC_W-(QBITS-ECC_FRAC)){1'b0}}, ecc, {(QBITS-ECC_FRAC){1'b0}}};
  assign one_minus_e2 = ONE_Q60 - e2;
  assign radius_q = {{(64-RADIUS_W-LEN_FRAC){1'b0}}, radius, {LEN_FRAC{1'b0}}};

  function automatic logic [OUT_W-1:0] finish_mm(input q60_t v);
    q60_t m, r;
    m = (mag64(v) + (64'd1 << (LEN_FRAC - 1))) >> LEN_FRAC;
    if (m > OUT_LIMIT_U) m = OUT_LIMIT_U;
    r = v[63] ? (64'd0 - m) : m;
    return r[OUT_W-1:0];
  endfunction

  // ---------------- sine and cosine series ----------------
  trig_t tr [TAYLOR_TERMS+1];
  logic  vt [TAYLOR_TERMS+1];

  always_comb begin
    tr[0].lat_t = ONE_Q60;
    tr[0].lat_s = '0;
    tr[0].lat_c = ONE_Q60;
    tr[0].lon_t = ONE_Q60;
    tr[0].lon_s = '0;
    tr[0].lon_c = ONE_Q60;
    tr[0].lat   = pt.lat;
    tr[0].lon   = pt.lon;
    tr[0].alt   = pt.alt;
  end
  assign vt[0] = pt_valid;

  for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
    localparam int K = k;
    // floor(x / K) = (x * RECIP) >> DIV_SHIFT, exact for x below 2^63
    localparam int DIV_SHIFT = 63 + $clog2(K);
    localparam logic [127:0] RECIP_FULL =
      ((128'd1 << DIV_SHIFT) + 128'(K - 1)) / 128'(K);
    localparam q60_t RECIP = 64'(RECIP_FULL);

    logic [1:0][63:0] tp, tq;
    trig_t sd, sq, nx;
    logic  sv, qv;
    q60_t  qlat, qlon;

    g2e_mulq #(.LANES(2), .SIDE_T(trig_t)) u_mul (
      .clk, .rst, .en,
      .in_valid (vt[k-1]),
      .a        ({tr[k-1].lon_t, tr[k-1].lat_t}),
      .b        ({tr[k-1].lon.m, tr[k-1].lat.m}),
      .side_in  (tr[k-1]),
      .out_valid(sv),
      .p        (tp),
      .side_out (sd)
    );

    // Next term: truncating divide by the term index
    g2e_mulq #(.LANES(2), .SIDE_T(trig_t), .SHIFT(DIV_SHIFT), .ROUND_HALF(1'b0)) u_div (
      .clk, .rst, .en,
      .in_valid (sv),
      .a        (tp),
      .b        ({RECIP, RECIP}),
      .side_in  (sd),
      .out_valid(qv),
      .p        (tq),
      .side_out (sq)
    );

    assign qlat = tq[0];
    assign qlon = tq[1];

    always_comb begin
      nx       = sq;
      nx.lat_t = qlat;
      nx.lon_t = qlon;
      case (K % 4)
        1: begin
          nx.lat_s = sq.lat_s + qlat;
          nx.lon_s = sq.lon_s + qlon;
        end
        2: begin
          nx.lat_c = sq.lat_c - qlat;
          nx.lon_c = sq.lon_c - qlon;
        end
        3: begin
          nx.lat_s = sq.lat_s - qlat;
          nx.lon_s = sq.lon_s - qlon;
        end
        default: begin
          nx.lat_c = sq.lat_c + qlat;
          nx.lon_c = sq.lon_c + qlon;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vt[k] <= 1'b0;
      end else if (en) begin
        vt[k] <= qv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) tr[k] <= nx;
    end
  end

  // Apply the fold signs
  geo_t g0;
  always_comb begin
    g0     = '0;
    g0.sl  = neg_if(tr[TAYLOR_TERMS].lat_s, tr[TAYLOR_TERMS].lat.rneg);
    g0.cl  = neg_if(tr[TAYLOR_TERMS].lat_c, tr[TAYLOR_TERMS].lat.cneg);
    g0.so  = neg_if(tr[TAYLOR_TERMS].lon_s, tr[TAYLOR_TERMS].lon.rneg);
    g0.co  = neg_if(tr[TAYLOR_TERMS].lon_c, tr[TAYLOR_TERMS].lon.cneg);
    g0.y   = ONE_Q60;
    g0.alt = tr[TAYLOR_TERMS].alt;
  end

  // ---------------- w = 1 - e2 sin^2 lat ----------------
  q60_t pa, pb;
  geo_t ga, gb;
  logic va, vb;

  g2e_mulq #(.LANES(1), .SIDE_T(geo_t)) u_sin2 (
    .clk, .rst, .en,
    .in_valid(vt[TAYLOR_TERMS]), .a(mag64(g0.sl)), .b(mag64(g0.sl)),
    .side_in(g0), .out_valid(va), .p(pa), .side_out(ga)
  );

  g2e_mulq #(.LANES(1), .SIDE_T(geo_t)) u_ecc (
    .clk, .rst, .en,
    .in_valid(va), .a(e2), .b(pa),
    .side_in(ga), .out_valid(vb), .p(pb), .side_out(gb)
  );

  // ---------------- Newton steps for 1/sqrt(w) ----------------
  geo_t nw [NEWTON_STEPS+1];
  logic nv [NEWTON_STEPS+1];

  always_comb begin
    nw[0]   = gb;
    nw[0].w = ONE_Q60 - pb;
  end
  assign nv[0] = vb;

  for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_newton
    q60_t p1, p2, p3;
    geo_t g1, g2, g3;
    logic v1, v2;

    g2e_mulq #(.LANES(1), .SIDE_T(geo_t)) u_yy (
      .clk, .rst, .en,
      .in_valid(nv[i]), .a(nw[i].y), .b(nw[i].y),
      .side_in(nw[i]), .out_valid(v1), .p(p1), .side_out(g1)
    );

    g2e_mulq #(.LANES(1), .SIDE_T(geo_t)) u_wyy (
      .clk, .rst, .en,
      .in_valid(v1), .a(g1.w), .b(p1),
      .side_in(g1), .out_valid(v2), .p(p2), .side_out(g2)
    );

    g2e_mulq #(.LANES(1), .SIDE_T(geo_t)) u_upd (
      .clk, .rst, .en,
      .in_valid(v2), .a(g2.y), .b(THREE_Q60 - p2),
      .side_in(g2), .out_valid(nv[i+1]), .p(p3), .side_out(g3)
    );

    always_comb begin
      nw[i+1]   = g3;
      nw[i+1].y = {1'b0, p3[63:1]};
    end
  end

  // ---------------- N, N + h, N(1 - e2) + h ----------------
  q60_t pn, pzr;
  geo_t gn, gn2, gp, gz;
  logic vn, vp;
  q60_t h;

  g2e_mulq #(.LANES(1), .SIDE_T(geo_t)) u_rad (
    .clk, .rst, .en,
    .in_valid(nv[NEWTON_STEPS]), .a(radius_q), .b(nw[NEWTON_STEPS].y),
    .side_in(nw[NEWTON_STEPS]), .out_valid(vn), .p(pn), .side_out(gn)
  );

  always_comb begin
    gn2   = gn;
    gn2.n = pn;
  end

  g2e_mulq #(.LANES(1), .SIDE_T(geo_t)) u_polar (
    .clk, .rst, .en,
    .in_valid(vn), .a(gn2.n), .b(one_minus_e2),
    .side_in(gn2), .out_valid(vp), .p(pzr), .side_out(gp)
  );

  assign h = {{(64-ALT_W){gp.alt[ALT_W-1]}}, gp.alt} << LEN_FRAC;

  always_comb begin
    gz    = gp;
    gz.p  = gp.n + h;
    gz.pz = pzr + h;
  end

  // ---------------- (N+h) cos lat and Z ----------------
  logic [1:0][63:0] pc;
  geo_t gc, gc2;
  logic vc;

  g2e_mulq #(.LANES(2), .SIDE_T(geo_t)) u_lat (
    .clk, .rst, .en,
    .in_valid(vp),
    .a({mag64(gz.pz), mag64(gz.p)}),
    .b({mag64(gz.sl), mag64(gz.cl)}),
    .side_in(gz), .out_valid(vc), .p(pc), .side_out(gc)
  );

  always_comb begin
    gc2     = gc;
    gc2.pcl = neg_if(pc[0], gc.p[63] ^ gc.cl[63]);
    gc2.z   = neg_if(pc[1], gc.pz[63] ^ gc.sl[63]);
  end

  // ---------------- X and Y ----------------
  logic [1:0][63:0] pd;
  geo_t gd;
  logic vd;
  q60_t xq, yq;

  g2e_mulq #(.LANES(2), .SIDE_T(geo_t)) u_lon (
    .clk, .rst, .en,
    .in_valid(vc),
    .a({mag64(gc2.pcl), mag64(gc2.pcl)}),
    .b({mag64(gc2.so), mag64(gc2.co)}),
    .side_in(gc2), .out_valid(vd), .p(pd), .side_out(gd)
  );

  assign xq = neg_if(pd[0], gd.pcl[63] ^ gd.co[63]);
  assign yq = neg_if(pd[1], gd.pcl[63] ^ gd.so[63]);

  // ---------------- output register: round to mm and saturate ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ecef.valid <= 1'b0;
    end else if (en) begin
      ecef.valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ecef.ecef_x_mm <= finish_mm(xq);
      ecef.ecef_y_mm <= finish_mm(yq);
      ecef.ecef_z_mm <= finish_mm(gd.z);
    end
  end

endmodule

// ===== src/geodetic_to_ecef.sv =====
// Throughput: one point per cycle while the output is not stalled; every multiply and
// every divide by a term index is a two-stage 32x32 partial-product unit.
// The series and the six Newton steps set the latency.
// Reset clears the pipeline valids and the queue and loads the WGS84 radius and e2.
// ----------------------------------------------------------------------------
// geodetic_to_ecef
// Geodetic latitude, longitude and altitude to ECEF X, Y, Z in millimetres.
// ----------------------------------------------------------------------------
`include "geodetic_to_ecef_macros.svh"

module geodetic_to_ecef #(
  parameter int ANGLE_FRACTION_BITS = g2e_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  g2e_in_if.sink                        geo,
  g2e_out_if.source                     ecef,
  input  logic                          cfg_we,
  input  logic [g2e_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [g2e_pkg::CFG_W-1:0]     cfg_data
);
  import g2e_pkg::*;

  logic [RADIUS_W-1:0] radius;
  logic [ECC_W-1:0]    ecc;
  logic                f_valid, f_ready, q_valid, q_ready;
  point_t              f_data, q_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      ecc    <= ECC_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_RADIUS: radius <= cfg_data[RADIUS_W-1:0];
        CFG_ECC:    ecc    <= cfg_data[ECC_W-1:0];
        default: ;
      endcase
    end
  end

  g2e_front #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_front (
    .clk, .rst, .geo,
    .pt_valid(f_valid), .pt_ready(f_ready), .pt(f_data)
  );

  g2e_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_data)
  );

  g2e_back u_back (
    .clk, .rst,
    .pt_valid(q_valid), .pt_ready(q_ready), .pt(q_data),
    .radius, .ecc, .ecef
  );

  // Checks
  `G2E_CHECK(a_no_pop_on_stall, q_valid && q_ready, !(ecef.valid && !ecef.ready), "queue popped while output stalled")
  `G2E_CHECK_NEXT(a_front_holds, f_valid && !f_ready, f_valid, "front dropped a point while queue full")
  `G2E_CHECK_RESET(a_cfg_reset, radius == RADIUS_RESET && ecc == ECC_RESET, "config not at reset value")
  `G2E_CHECK(a_out_range, ecef.valid, ecef.ecef_x_mm <= OUT_LIMIT && ecef.ecef_x_mm >= -OUT_LIMIT && ecef.ecef_y_mm <= OUT_LIMIT && ecef.ecef_y_mm >= -OUT_LIMIT && ecef.ecef_z_mm <= OUT_LIMIT && ecef.ecef_z_mm >= -OUT_LIMIT, "result outside saturation range")

endmodule
